// ===== hw/rtl/rkh_pkg.sv =====
// Shared types and constants of the hash search block.
`timescale 1ns / 1ps
package rkh_pkg;

	// Width of the polynomial hash and of the position fields in a result.
	localparam int HASH_BITS = 64;
	localparam int OUT_BITS  = 24;

	// Kind of character in an input item.
	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_TEXT    = 1'b1
	} op_t;

	// One input beat.
	typedef struct packed {
		op_t        op;
		logic [6:0] ch;
		logic       first;
		logic       last;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic                found;
		logic [OUT_BITS-1:0] position;
		logic [OUT_BITS-1:0] match_count;
		logic                done_res;
		logic                pattern_error;
	} result_t;

	// Classified command held in the queue between front and back.
	typedef struct packed {
		logic       is_text;
		logic       clr;
		logic       last;
		logic [6:0] ch;
	} cmd_t;

	// Work handed from the sequencer to the match pipeline.
	typedef struct packed {
		logic                 valid;
		logic                 clr_count;
		logic                 last;
		logic                 povf;
		logic                 elig;
		logic [OUT_BITS-1:0]  pos;
		logic [HASH_BITS-1:0] prefix;
		logic [HASH_BITS-1:0] lead;
		logic [HASH_BITS-1:0] ppow;
		logic [HASH_BITS-1:0] rhs;
	} job_t;

endpackage

// ===== hw/rtl/rkh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rkh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/rkh_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the sequencer.
`timescale 1ns / 1ps
module rkh_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rkh_pkg::item_t item_data,
	output logic           cmd_valid,
	output rkh_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);
	import rkh_pkg::*;

	localparam int QDEPTH = 2;

	cmd_t       ent_q [QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       new_cmd;

	// The queue takes a beat whenever it has a free entry.
	assign item_stall = (fill_q == 2'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (fill_q != 2'd0);
	assign cmd        = ent_q[rd_q];

	// Classify the beat; the last flag only means something for text.
	always_comb begin
		new_cmd.is_text = (item_data.op == OP_TEXT);
		new_cmd.clr     = item_data.first;
		new_cmd.last    = (item_data.op == OP_TEXT) && item_data.last;
		new_cmd.ch      = item_data.ch;
	end

	// Queue entries carry payload only and need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

`ifndef SYNTH
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("sequencer popped an empty command queue");
`endif

endmodule

// ===== hw/rtl/rkh_back.sv =====
// Sequencer: keeps the pattern and text hash state and the prefix ring, issues match jobs.
`timescale 1ns / 1ps
module rkh_back #(
	parameter int MAX_PATTERN   = 256,
	parameter int POSITION_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  rkh_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          room,
	output logic          reserve,
	output rkh_pkg::job_t job
);
	import rkh_pkg::*;

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int CW = ((POSITION_BITS > LW) ? POSITION_BITS : LW) + 1;
	localparam logic [HASH_BITS-1:0]     HASH_BASE   = HASH_BITS'(101);
	localparam logic [HASH_BITS-1:0]     CHAR_OFFSET = HASH_BITS'(64);
	localparam logic [HASH_BITS-1:0]     ONE         = HASH_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_LIMIT   = '1;
	localparam logic [LW-1:0]            LEN_MAX     = LW'(MAX_PATTERN);
	localparam logic [AW-1:0]            SLOT_LAST   = AW'(MAX_PATTERN - 1);
	localparam logic [AW:0]              DEPTH_EXT   = (AW + 1)'(MAX_PATTERN);

	typedef enum logic {
		ST_LOAD,
		ST_EXEC
	} state_t;

	// Weight of a character times a hash word: (ch - 64) * x, modulo 2^64.
	function automatic logic [HASH_BITS-1:0] wmul(logic [6:0] c, logic [HASH_BITS-1:0] x);
		wmul = x * HASH_BITS'(c) - x * CHAR_OFFSET;
	endfunction

	state_t                 st_q;
	cmd_t                   cur_q;
	job_t                   job_q;

	// Pattern state.
	logic [HASH_BITS-1:0]     phash_q;
	logic [HASH_BITS-1:0]     ppow_q;
	logic [LW-1:0]            plen_q;
	logic                     povf_q;
	// Text state.
	logic [HASH_BITS-1:0]     tpow_q;
	logic [HASH_BITS-1:0]     prefix_q;
	logic [POSITION_BITS-1:0] tpos_q;
	logic [AW-1:0]            slot_q;
	// Cross terms: pattern hash times text power, pattern power times text power.
	logic [HASH_BITS-1:0]     hmix_q;
	logic [HASH_BITS-1:0]     rmix_q;

	// Next-state values.
	logic [HASH_BITS-1:0]     phash_n;
	logic [HASH_BITS-1:0]     ppow_n;
	logic [LW-1:0]            plen_n;
	logic                     povf_n;
	logic [HASH_BITS-1:0]     tpow_n;
	logic [HASH_BITS-1:0]     prefix_n;
	logic [POSITION_BITS-1:0] tpos_n;
	logic [AW-1:0]            slot_n;
	logic [HASH_BITS-1:0]     hmix_n;
	logic [HASH_BITS-1:0]     rmix_n;
	job_t                     job_n;

	// Values after a pattern restart.
	logic [HASH_BITS-1:0]     p_h0;
	logic [HASH_BITS-1:0]     p_pp0;
	logic [LW-1:0]            p_l0;
	logic                     p_ov0;
	logic [HASH_BITS-1:0]     p_hm0;
	logic [HASH_BITS-1:0]     p_r0;
	// Values after a text restart.
	logic [HASH_BITS-1:0]     t_tp0;
	logic [HASH_BITS-1:0]     t_pf0;
	logic [POSITION_BITS-1:0] t_i0;
	logic [AW-1:0]            t_sl0;
	logic [HASH_BITS-1:0]     t_hm0;
	logic [HASH_BITS-1:0]     t_r0;
	logic [HASH_BITS-1:0]     t_pf1;
	logic [HASH_BITS-1:0]     t_hm1;
	logic                     t_hashed;

	logic [CW-1:0]            i_next;
	logic [CW-1:0]            len_c;
	logic [CW-1:0]            pos_c;
	logic [CW+OUT_BITS-1:0]   pos_ext;
	logic                     win_late;

	logic [AW:0]              slot_ext;
	logic [AW:0]              len_ext;
	logic [AW:0]              back_ext;
	logic [AW-1:0]            raddr;
	logic                     ring_we;
	logic [HASH_BITS-1:0]     ring_rdata;

	// Take a command when idle; text needs a result slot reserved downstream.
	assign cmd_pop = (st_q == ST_LOAD) && cmd_valid && (!cmd.is_text || room);
	assign reserve = cmd_pop && cmd.is_text;
	assign job     = job_q;

	// Ring slot of the prefix just before the window: slot minus pattern length, wrapped.
	always_comb begin
		slot_ext = {1'b0, slot_q};
		len_ext  = (AW + 1)'(plen_q);
		if (plen_q == '0) begin
			back_ext = slot_ext;
		end else if (slot_ext >= len_ext) begin
			back_ext = slot_ext - len_ext;
		end else begin
			back_ext = slot_ext + DEPTH_EXT - len_ext;
		end
		raddr = back_ext[AW-1:0];
	end

	rkh_ram #(
		.WIDTH(HASH_BITS),
		.DEPTH(MAX_PATTERN)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(t_sl0),
		.wdata(t_pf1),
		.re   (cmd_pop),
		.raddr(raddr),
		.rdata(ring_rdata)
	);

	// State as seen after the restart flag of the current command.
	assign p_h0  = cur_q.clr ? '0 : phash_q;
	assign p_pp0 = cur_q.clr ? ONE : ppow_q;
	assign p_l0  = cur_q.clr ? '0 : plen_q;
	assign p_ov0 = cur_q.clr ? 1'b0 : povf_q;
	assign p_hm0 = cur_q.clr ? '0 : hmix_q;
	assign p_r0  = cur_q.clr ? tpow_q : rmix_q;

	assign t_tp0 = cur_q.clr ? ONE : tpow_q;
	assign t_pf0 = cur_q.clr ? '0 : prefix_q;
	assign t_i0  = cur_q.clr ? '0 : tpos_q;
	assign t_sl0 = cur_q.clr ? '0 : slot_q;
	assign t_hm0 = cur_q.clr ? phash_q : hmix_q;
	assign t_r0  = cur_q.clr ? ppow_q : rmix_q;

	assign t_pf1    = t_pf0 + wmul(cur_q.ch, t_tp0);
	assign t_hm1    = t_hm0 * HASH_BASE;
	assign t_hashed = (t_i0 != POS_LIMIT);

	// Window bookkeeping for a text character.
	assign i_next   = CW'(t_i0) + CW'(1);
	assign len_c    = CW'(plen_q);
	assign win_late = (i_next > len_c);
	assign pos_c    = i_next - len_c + CW'(1);
	assign pos_ext  = (CW + OUT_BITS)'(pos_c);

	assign ring_we  = (st_q == ST_EXEC) && cur_q.is_text && t_hashed;

	// Execute step of the current command.
	always_comb begin
		phash_n  = phash_q;
		ppow_n   = ppow_q;
		plen_n   = plen_q;
		povf_n   = povf_q;
		tpow_n   = tpow_q;
		prefix_n = prefix_q;
		tpos_n   = tpos_q;
		slot_n   = slot_q;
		hmix_n   = hmix_q;
		rmix_n   = rmix_q;

		job_n.valid     = cur_q.is_text;
		job_n.clr_count = cur_q.clr;
		job_n.last      = cur_q.last;
		job_n.povf      = povf_q;
		job_n.elig      = t_hashed && !povf_q && (plen_q != '0) && (i_next >= len_c);
		job_n.pos       = pos_ext[OUT_BITS-1:0];
		job_n.prefix    = t_pf1;
		job_n.lead      = win_late ? ring_rdata : '0;
		job_n.ppow      = ppow_q;
		job_n.rhs       = t_hm1;

		if (cur_q.is_text) begin
			tpow_n   = t_tp0;
			prefix_n = t_pf0;
			tpos_n   = t_i0;
			slot_n   = t_sl0;
			hmix_n   = t_hm0;
			rmix_n   = t_r0;
			if (t_hashed) begin
				tpow_n   = t_tp0 * HASH_BASE;
				prefix_n = t_pf1;
				tpos_n   = t_i0 + POSITION_BITS'(1);
				slot_n   = (t_sl0 == SLOT_LAST) ? '0 : t_sl0 + AW'(1);
				hmix_n   = t_hm1;
				rmix_n   = t_r0 * HASH_BASE;
			end
		end else begin
			phash_n = p_h0;
			ppow_n  = p_pp0;
			plen_n  = p_l0;
			povf_n  = p_ov0;
			hmix_n  = p_hm0;
			rmix_n  = p_r0;
			if (p_l0 == LEN_MAX) begin
				// Characters beyond the maximum length are dropped.
				povf_n = 1'b1;
			end else begin
				phash_n = p_h0 + wmul(cur_q.ch, p_pp0);
				hmix_n  = p_hm0 + wmul(cur_q.ch, p_r0);
				ppow_n  = p_pp0 * HASH_BASE;
				rmix_n  = p_r0 * HASH_BASE;
				plen_n  = p_l0 + LW'(1);
			end
		end
	end

	// Sequencer: load a command and start the ring read, then execute it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_LOAD;
			cur_q    <= '0;
			job_q    <= '0;
			phash_q  <= '0;
			ppow_q   <= ONE;
			plen_q   <= '0;
			povf_q   <= 1'b0;
			tpow_q   <= ONE;
			prefix_q <= '0;
			tpos_q   <= '0;
			slot_q   <= '0;
			hmix_q   <= '0;
			rmix_q   <= ONE;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					job_q.valid <= 1'b0;
					if (cmd_pop) begin
						cur_q <= cmd;
						st_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					job_q    <= job_n;
					phash_q  <= phash_n;
					ppow_q   <= ppow_n;
					plen_q   <= plen_n;
					povf_q   <= povf_n;
					tpow_q   <= tpow_n;
					prefix_q <= prefix_n;
					tpos_q   <= tpos_n;
					slot_q   <= slot_n;
					hmix_q   <= hmix_n;
					rmix_q   <= rmix_n;
					st_q     <= ST_LOAD;
				end
				default: begin
					job_q.valid <= 1'b0;
					st_q        <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXEC) |=> (st_q == ST_LOAD))
		else $error("execute step lasted more than one cycle");
	a_job_from_text: assert property (@(posedge clk) disable iff (!arst_n)
		job_q.valid |-> $past((st_q == ST_EXEC) && cur_q.is_text))
		else $error("match job issued without an executed text character");
`endif

endmodule

// ===== hw/rtl/rkh_match.sv =====
// Match pipeline: split 64-bit hash product, compare, match counter and result buffer.
`timescale 1ns / 1ps
module rkh_match #(
	parameter int POSITION_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rkh_pkg::job_t    job,
	input  logic             reserve,
	output logic             room,
	output logic             res_valid,
	input  logic             res_stall,
	output rkh_pkg::result_t res_data
);
	import rkh_pkg::*;

	localparam int OUT_DEPTH = 4;
	localparam int PW        = $clog2(OUT_DEPTH);
	localparam int FW        = $clog2(OUT_DEPTH + 1);
	localparam logic [POSITION_BITS-1:0] CNT_LIMIT = '1;

	typedef struct packed {
		logic                clr;
		logic                last;
		logic                povf;
		logic                elig;
		logic [OUT_BITS-1:0] pos;
	} meta_t;

	logic                 v_s1, v_s2, v_s3, v_s4;
	meta_t                meta_s1, meta_s2, meta_s3, meta_s4;
	logic [HASH_BITS-1:0] diff_s1, pp_s1, rhs_s1;
	logic [HASH_BITS-1:0] pll_s2, diff_s2, pp_s2, rhs_s2;
	logic [31:0]          acc_s3, lo_s3, dhi_s3, plo_s3;
	logic [HASH_BITS-1:0] rhs_s3;
	logic [HASH_BITS-1:0] lhs_s4, rhs_s4;

	logic [HASH_BITS-1:0] pll_c;
	logic                 found;
	logic                 push;
	logic                 drop;
	logic                 pop_out;
	logic [POSITION_BITS-1:0]          cnt_q;
	logic [POSITION_BITS-1:0]          cnt_base;
	logic [POSITION_BITS-1:0]          cnt_n;
	logic [POSITION_BITS+OUT_BITS-1:0] cnt_ext;
	result_t              res_n;

	result_t              buf_q [OUT_DEPTH];
	logic [PW-1:0]        wp_q;
	logic [PW-1:0]        rp_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        resv_q;

	assign pll_c = diff_s1[31:0] * pp_s1[31:0];

	// Product pipeline: the first stage forms the window difference, each later stage adds one 32x32 partial product.
	always_ff @(posedge clk) begin
		meta_s1 <= {job.clr_count, job.last, job.povf, job.elig, job.pos};
		diff_s1 <= job.prefix - job.lead;
		pp_s1   <= job.ppow;
		rhs_s1  <= job.rhs;

		meta_s2 <= meta_s1;
		pll_s2  <= pll_c;
		diff_s2 <= diff_s1;
		pp_s2   <= pp_s1;
		rhs_s2  <= rhs_s1;

		meta_s3 <= meta_s2;
		acc_s3  <= pll_s2[63:32] + 32'(diff_s2[31:0] * pp_s2[63:32]);
		lo_s3   <= pll_s2[31:0];
		dhi_s3  <= diff_s2[63:32];
		plo_s3  <= pp_s2[31:0];
		rhs_s3  <= rhs_s2;

		meta_s4 <= meta_s3;
		lhs_s4  <= {acc_s3 + 32'(dhi_s3 * plo_s3), lo_s3};
		rhs_s4  <= rhs_s3;
	end

	// Compare, count and form the result beat.
	always_comb begin
		found    = v_s4 && meta_s4.elig && (lhs_s4 == rhs_s4);
		push     = v_s4 && (found || meta_s4.last);
		drop     = v_s4 && !push;
		cnt_base = meta_s4.clr ? '0 : cnt_q;
		cnt_n    = (found && (cnt_base != CNT_LIMIT)) ?
			cnt_base + POSITION_BITS'(1) : cnt_base;
		cnt_ext  = (POSITION_BITS + OUT_BITS)'(cnt_n);

		res_n.found         = found;
		res_n.position      = found ? meta_s4.pos : '0;
		res_n.match_count   = cnt_ext[OUT_BITS-1:0];
		res_n.done_res      = meta_s4.last;
		res_n.pattern_error = meta_s4.povf;
	end

	// Result buffer; slots are reserved when the sequencer takes a text character.
	assign pop_out   = res_valid && !res_stall;
	assign res_valid = (fill_q != '0);
	assign res_data  = buf_q[rp_q];
	assign room      = (resv_q < FW'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			cnt_q  <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
			resv_q <= '0;
		end else begin
			v_s1 <= job.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				cnt_q <= cnt_n;
			end
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop_out) begin
				rp_q <= rp_q + PW'(1);
			end
			fill_q <= fill_q + FW'(push) - FW'(pop_out);
			resv_q <= resv_q + FW'(reserve) - FW'(pop_out) - FW'(drop);
		end
	end

`ifndef SYNTH
	a_fill_within_resv: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= resv_q)
		else $error("result buffer holds more beats than were reserved");
	a_push_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q < FW'(OUT_DEPTH)))
		else $error("result pushed into a full buffer");
`endif

endmodule

// ===== hw/rtl/rabin_karp_hash_search.sv =====
// Top level of the Rabin-Karp hash substring search block.
`timescale 1ns / 1ps
// Hash-only substring search, polynomial hash modulo 2^64 with base 101. Load the
// pattern as beats with op set to pattern (first restarts it), then stream text beats
// (first restarts the text, last closes it). A result beat comes out for each window
// whose hash matches and for the last text character; hash collisions count as matches.
// The sequencer takes a new character only after the last one is done, and takes text
// only while a result slot is free: a load state reads the prefix ring memory and an
// execute state updates the hash state. A result beat comes out behind four stages
// that form the window difference and build the 64-bit product from 32x32 partial
// products. A four-beat result buffer and a two-beat input queue let each side stall on
// its own. The prefix ring needs no clearing pass: only entries written since the text
// started are ever read.
module rabin_karp_hash_search #(
	parameter int MAX_PATTERN   = 256,
	parameter int POSITION_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rkh_pkg::item_t   item_data,
	output logic             res_valid,
	input  logic             res_stall,
	output rkh_pkg::result_t res_data
);
	import rkh_pkg::*;

	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;
	logic  room;
	logic  reserve;
	job_t  job;

	rkh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data (item_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rkh_back #(
		.MAX_PATTERN  (MAX_PATTERN),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.room     (room),
		.reserve  (reserve),
		.job      (job)
	);

	rkh_match #(
		.POSITION_BITS(POSITION_BITS)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.reserve  (reserve),
		.room     (room),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Rabin-Karp hash substring search block.
`timescale 1ns / 1ps
module tb;
	import rkh_pkg::*;

	localparam int          MAX_PAT     = 256;
	localparam int          POS_BITS    = 24;
	localparam logic [23:0] POS_FULL    = 24'hFFFFFF;
	localparam logic [63:0] HASH_BASE   = 64'd101;
	localparam logic [63:0] CHAR_BIAS   = 64'd64;
	localparam logic [6:0]  CH_A        = 7'd65;
	localparam logic [6:0]  CH_B        = 7'd66;
	localparam int          ITEM_TARGET = 1850;
	localparam int          CYCLE_LIMIT = 300000;
	localparam int          HOLD_PERIOD = 2500;
	localparam int          HOLD_START  = 1200;
	localparam int          HOLD_CYCLES = 400;

	// Character sets used when building text and patterns.
	localparam int SPAN_TWO  = 0;
	localparam int SPAN_FOUR = 1;
	localparam int SPAN_ALL  = 2;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HALF,
		RX_HEAVY
	} rx_mode_t;

	logic    clk;
	logic    arst_n     = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item_data  = '0;
	logic    res_valid;
	logic    res_stall  = 1'b0;
	result_t res_data;

	// Beats waiting to be sent, and result beats the search should still produce.
	item_t   feed[$];
	result_t awaited[$];
	result_t want;

	int unsigned n_queued    = 0;
	int unsigned n_accepted  = 0;
	int unsigned n_results   = 0;
	int unsigned n_errors    = 0;
	int unsigned cycle_count = 0;

	// Sender burst shaping.
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	// Receiver stall pattern.
	rx_mode_t    rx_mode   = RX_FREE;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	int unsigned rx_cycle  = 0;

	// Search state as the block should hold it.
	logic [63:0] pat_hash = 64'd0;
	logic [63:0] pat_pow  = 64'd1;
	int unsigned pat_len  = 0;
	bit          pat_ovf  = 1'b0;
	logic [63:0] txt_pow  = 64'd1;
	logic [63:0] prefix   = 64'd0;
	logic [63:0] prefix_hist[MAX_PAT];
	logic [23:0] txt_pos  = 24'd0;
	logic [23:0] hits     = 24'd0;

	rabin_karp_hash_search #(
		.MAX_PATTERN(MAX_PAT),
		.POSITION_BITS(POS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the search by one accepted beat and record any result it must give.
	task automatic search_step(input item_t b);
		logic [63:0] w;
		logic [63:0] lead;
		logic [63:0] diff;
		int unsigned i;
		int unsigned s;
		bit          hit;
		logic [23:0] at;
		result_t     r;
		w   = 64'(b.ch) - CHAR_BIAS;
		hit = 1'b0;
		at  = 24'd0;
		if (b.op == OP_PATTERN) begin
			if (b.first) begin
				pat_hash = 64'd0;
				pat_pow  = 64'd1;
				pat_len  = 0;
				pat_ovf  = 1'b0;
			end
			// Characters beyond the maximum length are dropped and flag the pattern.
			if (pat_len >= MAX_PAT) begin
				pat_ovf = 1'b1;
			end else begin
				pat_hash = pat_hash + w * pat_pow;
				pat_pow  = pat_pow * HASH_BASE;
				pat_len++;
			end
		end else begin
			if (b.first) begin
				txt_pow = 64'd1;
				prefix  = 64'd0;
				txt_pos = 24'd0;
				hits    = 24'd0;
			end
			if (txt_pos != POS_FULL) begin
				i      = txt_pos;
				prefix = prefix + w * txt_pow;
				// Only a window that has fully arrived is compared.
				if (!pat_ovf && pat_len != 0 && i + 1 >= pat_len) begin
					s    = i + 1 - pat_len;
					lead = (s == 0) ? 64'd0 : prefix_hist[(s - 1) % MAX_PAT];
					diff = prefix - lead;
					if (diff * pat_pow == pat_hash * txt_pow * HASH_BASE) begin
						hit = 1'b1;
						at  = 24'(s + 1);
					end
				end
				prefix_hist[i % MAX_PAT] = prefix;
				txt_pow = txt_pow * HASH_BASE;
				txt_pos = 24'(i + 1);
				if (hit && hits != POS_FULL)
					hits = hits + 24'd1;
			end
			if (hit || b.last) begin
				r.found         = hit;
				r.position      = at;
				r.match_count   = hits;
				r.done_res      = b.last;
				r.pattern_error = pat_ovf;
				awaited.insert(awaited.size(), r);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("mismatch: %s", msg);
	endtask

	function automatic void add_beat(input bit is_text, input logic [6:0] ch,
			input bit first, input bit last);
		item_t b;
		b.op    = is_text ? OP_TEXT : OP_PATTERN;
		b.ch    = ch;
		b.first = first;
		b.last  = last;
		feed.insert(feed.size(), b);
		n_queued++;
	endfunction

	function automatic logic [6:0] pick_char(input int span);
		if (span == SPAN_TWO)
			return CH_A + 7'($urandom_range(0, 1));
		else if (span == SPAN_FOUR)
			return CH_A + 7'($urandom_range(0, 3));
		return 7'($urandom_range(0, 127));
	endfunction

	// Load a pattern, then a text with some copies of it planted at random places.
	task automatic gen_search(input int plen, input int tlen, input int span, input int plants);
		logic [6:0] pat[$];
		logic [6:0] txt[$];
		int         at;
		for (int k = 0; k < plen; k++)
			pat.insert(pat.size(), pick_char(span));
		for (int k = 0; k < plen; k++)
			add_beat(1'b0, pat[k], k == 0, $urandom_range(0, 1));
		for (int k = 0; k < tlen; k++)
			txt.insert(txt.size(), pick_char(span));
		if (plen <= tlen) begin
			repeat (plants) begin
				at = $urandom_range(0, tlen - plen);
				for (int k = 0; k < plen; k++)
					txt[at + k] = pat[k];
			end
		end
		for (int k = 0; k < tlen; k++)
			add_beat(1'b1, txt[k], k == 0, k == tlen - 1);
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || awaited.size() != 0)
			@(posedge clk);
	endtask

	// Sender: offers beats from the feed in bursts with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				search_step(item_data);
				n_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (feed.size() != 0) begin
					item_data  <= feed.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode now and then, with a long hold at intervals.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_mode   <= RX_FREE;
			mode_left <= 0;
			hold_left <= 0;
			rx_cycle  <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(16, 160);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else if (rx_cycle % HOLD_PERIOD == HOLD_START) begin
				hold_left <= HOLD_CYCLES;
				res_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FREE: begin
						res_stall <= 1'b0;
					end
					RX_LIGHT: begin
						res_stall <= ($urandom_range(0, 3) == 0);
					end
					RX_HALF: begin
						res_stall <= ($urandom_range(0, 1) == 0);
					end
					default: begin
						res_stall <= ($urandom_range(0, 9) < 8);
					end
				endcase
			end
		end
	end

	// Result checker: each accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result beat %0d arrived with none expected",
					n_results));
			end else begin
				want = awaited.pop_front();
				if (res_data.found !== want.found)
					report_mismatch($sformatf("beat %0d found %0b, expected %0b",
						n_results, res_data.found, want.found));
				if (res_data.position !== want.position)
					report_mismatch($sformatf("beat %0d position %0d, expected %0d",
						n_results, res_data.position, want.position));
				if (res_data.match_count !== want.match_count)
					report_mismatch($sformatf("beat %0d match_count %0d, expected %0d",
						n_results, res_data.match_count, want.match_count));
				if (res_data.done_res !== want.done_res)
					report_mismatch($sformatf("beat %0d done_res %0b, expected %0b",
						n_results, res_data.done_res, want.done_res));
				if (res_data.pattern_error !== want.pattern_error)
					report_mismatch($sformatf("beat %0d pattern_error %0b, expected %0b",
						n_results, res_data.pattern_error, want.pattern_error));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int  r;
		int  n;
		int  span;
		bit  paused;
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Text with no pattern loaded yet never matches; extreme character codes.
		add_beat(1'b1, 7'd0, 1'b1, 1'b1);
		add_beat(1'b1, 7'd127, 1'b1, 1'b1);
		// Pattern "AB"; the last flag on a pattern beat is ignored.
		add_beat(1'b0, CH_A, 1'b1, 1'b0);
		add_beat(1'b0, CH_B, 1'b0, 1'b1);
		// A text shorter than the pattern cannot match.
		add_beat(1'b1, CH_A, 1'b1, 1'b1);
		// "ABAB" matches at the first and third characters.
		add_beat(1'b1, CH_A, 1'b1, 1'b0);
		add_beat(1'b1, CH_B, 1'b0, 1'b0);
		add_beat(1'b1, CH_A, 1'b0, 1'b0);
		add_beat(1'b1, CH_B, 1'b0, 1'b1);
		// Pattern swapped to "B" in the middle of a text.
		add_beat(1'b1, CH_A, 1'b1, 1'b0);
		add_beat(1'b1, CH_B, 1'b0, 1'b0);
		add_beat(1'b0, CH_B, 1'b1, 1'b0);
		add_beat(1'b1, CH_B, 1'b0, 1'b0);
		add_beat(1'b1, CH_A, 1'b0, 1'b1);
		// Single character patterns at both ends of the code range.
		add_beat(1'b0, 7'd0, 1'b1, 1'b0);
		add_beat(1'b1, 7'd0, 1'b1, 1'b0);
		add_beat(1'b1, 7'd127, 1'b0, 1'b0);
		add_beat(1'b1, 7'd0, 1'b0, 1'b1);
		add_beat(1'b0, 7'd127, 1'b1, 1'b1);
		add_beat(1'b1, 7'd127, 1'b1, 1'b0);
		add_beat(1'b1, 7'd64, 1'b0, 1'b1);
		wait_drained();

		// Longest pattern matched across the full history, then two characters too many.
		gen_search(MAX_PAT, MAX_PAT + 6, SPAN_TWO, 1);
		add_beat(1'b0, CH_A, 1'b0, 1'b0);
		add_beat(1'b0, CH_B, 1'b0, 1'b1);
		for (int k = 0; k < 4; k++)
			add_beat(1'b1, CH_A + 7'(k % 2), k == 0, k == 3);

		while (n_queued < ITEM_TARGET) begin
			if (!paused && n_queued > ITEM_TARGET / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			r    = $urandom_range(0, 99);
			span = ($urandom_range(0, 4) == 0) ? SPAN_ALL : $urandom_range(SPAN_TWO, SPAN_FOUR);
			if (r < 60) begin
				gen_search($urandom_range(1, 4), $urandom_range(1, 32), span,
					$urandom_range(0, 2));
			end else if (r < 70) begin
				gen_search($urandom_range(5, 24), $urandom_range(1, 64), span,
					$urandom_range(0, 2));
			end else if (r < 80) begin
				// Noise: every field at random.
				repeat ($urandom_range(1, 8))
					add_beat($urandom_range(0, 1), 7'($urandom_range(0, 127)),
						$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
			end else if (r < 90) begin
				// Text carried on without a restart, possibly after an earlier last.
				n = $urandom_range(1, 24);
				for (int k = 0; k < n; k++)
					add_beat(1'b1, pick_char(span), 1'b0, k == n - 1);
			end else begin
				// Pattern grown in the middle of a text, then more text.
				repeat ($urandom_range(1, 3))
					add_beat(1'b0, pick_char(span), 1'b0, 1'b0);
				n = $urandom_range(1, 16);
				for (int k = 0; k < n; k++)
					add_beat(1'b1, pick_char(span), 1'b0, k == n - 1);
			end
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
